>>> rtl/assert_macros.svh
// assertion macros for the block bitmap free-space manager
// no dependencies; taken in by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define BBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BBF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bbf_pkg.sv
// package for the block bitmap free-space manager
// constants, function and status codes; no dependencies
`default_nettype none

package bbf_pkg;
  localparam int BLOCKS_PER_WORD = 128;
  localparam int NUM_WORDS       = 1024;

  localparam int SHIFT_W = 5;
  localparam int SIZE_W  = 18;
  localparam int FUNC_W  = 2;
  localparam int OFF_W   = 47;
  localparam int LEN_W   = 48;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 18'd131072;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BLOCKS = 1'd1;

  localparam logic [FUNC_W-1:0] FUNC_TOGGLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FORMAT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISALIGN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_LEN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;
endpackage

`default_nettype wire

>>> rtl/bbf_scan.sv
// bit search unit: first bit at or above a start position equal to a wanted value
// depends on nothing but its parameter
`default_nettype none

module bbf_scan #(
  parameter int BPW = 128
) (
  input  wire logic [BPW-1:0]         data,
  input  wire logic [$clog2(BPW)-1:0] lo,
  input  wire logic                   want,
  output logic                        hit,
  output logic [$clog2(BPW)-1:0]      idx
);
  localparam int BIT_W = $clog2(BPW);

  logic [BPW-1:0] w;

  always_comb begin
    w   = (want ? data : ~data) & ({BPW{1'b1}} << lo);
    hit = |w;
    idx = '0;
    for (int i = BPW - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
  end
endmodule

`default_nettype wire

>>> rtl/block_bitmap_freelist_core.sv
// block bitmap free-space manager, top level
// depends on bbf_pkg, bbf_scan and assert_macros.svh
// restart and misaligned or zero-length toggles answer from idle; the range check is made in S_CHK;
// a toggle reads then writes each word touched; next-extent reads and scans each word; format writes every word
// one item at a time, busy high while working
// after reset the bitmap is swept to zero, word by word, with busy high
`default_nettype none
`include "assert_macros.svh"

module block_bitmap_freelist_core #(
  parameter int BLOCKS_PER_WORD = bbf_pkg::BLOCKS_PER_WORD,
  parameter int NUM_WORDS       = bbf_pkg::NUM_WORDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bbf_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [bbf_pkg::OFF_W-1:0]      in_byte_offset,
  input  wire logic [bbf_pkg::LEN_W-1:0]      in_byte_length,
  input  wire logic                           cfg_we,
  input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [bbf_pkg::SIZE_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [bbf_pkg::OFF_W-1:0]           out_ext_offset,
  output logic [bbf_pkg::LEN_W-1:0]           out_ext_length,
  output logic [bbf_pkg::STAT_W-1:0]          out_status
);
  localparam int BPW     = BLOCKS_PER_WORD;
  localparam int BIT_W   = $clog2(BPW);
  localparam int WORD_AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL   = NUM_WORDS * BPW;
  localparam int TW      = $clog2(TOTAL) + 1;
  localparam int BLK_W   = (TW > bbf_pkg::SIZE_W + 1) ? TW : bbf_pkg::SIZE_W + 1;
  localparam int HI_W    = BLK_W - BIT_W;
  localparam int PAD_W   = BLK_W - WORD_AW - BIT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_TWR  = 3'd4;
  localparam logic [2:0] S_SRD  = 3'd5;
  localparam logic [2:0] S_SEV  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       fmt_r, fmt_nxt;
  logic       phase_r, phase_nxt;
  logic [WORD_AW-1:0] word_r, word_nxt;
  logic [BLK_W-1:0]   from_r, from_nxt;
  logic [BLK_W-1:0]   start_r, start_nxt;
  logic [BLK_W-1:0]   cursor_r, cursor_nxt;
  logic [BLK_W-1:0]   a_r, a_nxt;
  logic [BLK_W-1:0]   b_r, b_nxt;
  logic [bbf_pkg::LEN_W-1:0] sb_r, sb_nxt;
  logic [bbf_pkg::LEN_W-1:0] nb_r, nb_nxt;
  logic [bbf_pkg::SHIFT_W-1:0] shift_r;
  logic [bbf_pkg::SIZE_W-1:0]  size_r;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic [bbf_pkg::OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [bbf_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [bbf_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [BPW-1:0] mem [NUM_WORDS];
  logic [BPW-1:0] rdata_r;
  logic           mem_we;
  logic [WORD_AW-1:0] mem_waddr, mem_raddr;
  logic [BPW-1:0] mem_wdata;

  logic [BLK_W-1:0] s_clamp, count;
  logic [BLK_W-1:0] base, nxt_base, sbase, snext, pos;
  logic [bbf_pkg::LEN_W-1:0] low_mask;
  logic [bbf_pkg::LEN_W:0]   range_sum;
  logic [BIT_W:0]   hi;
  logic [BIT_W-1:0] lo;
  logic [BPW:0]     ones_x;
  logic [BPW-1:0]   tmask, fword;
  logic             scan_hit;
  logic [BIT_W-1:0] scan_idx;
  logic [63:0]      eoff_w, elen_w, elen_end_w;

  always_comb begin
    s_clamp = (BLK_W'(size_r) > BLK_W'(TOTAL)) ? BLK_W'(TOTAL) : BLK_W'(size_r);
    count   = ((s_clamp + BLK_W'(BPW - 1)) >> BIT_W) << BIT_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= bbf_pkg::SHIFT_RST;
      size_r  <= bbf_pkg::SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bbf_pkg::REG_BLOCK_SHIFT: shift_r <= cfg_wdata[bbf_pkg::SHIFT_W-1:0];
        bbf_pkg::REG_SIZE_BLOCKS: size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  bbf_scan #(.BPW(BPW)) u_scan (
    .data (rdata_r),
    .lo   (from_r[BIT_W-1:0]),
    .want (phase_r),
    .hit  (scan_hit),
    .idx  (scan_idx)
  );

  always_comb begin
    base     = {{PAD_W{1'b0}}, word_r, {BIT_W{1'b0}}};
    nxt_base = base + BLK_W'(BPW);
    sbase    = {from_r[BLK_W-1:BIT_W], {BIT_W{1'b0}}};
    snext    = sbase + BLK_W'(BPW);
    pos      = {from_r[BLK_W-1:BIT_W], scan_idx};
    ones_x   = '1;
    lo       = (base <= a_r) ? a_r[BIT_W-1:0] : '0;
    hi       = (nxt_base >= b_r) ? (BIT_W+1)'(b_r - base) : (BIT_W+1)'(BPW);
    tmask    = BPW'((ones_x << lo) & ~(ones_x << hi));
    if (base >= count) fword = '0;
    else if (base >= s_clamp) fword = '1;
    else if (nxt_base > s_clamp) fword = {BPW{1'b1}} << s_clamp[BIT_W-1:0];
    else fword = '0;
    if (fmt_r) begin
      if (word_r == '0) fword[0] = ~fword[0];
    end else begin
      fword = '0;
    end
    low_mask   = ~({bbf_pkg::LEN_W{1'b1}} << shift_r);
    range_sum  = {1'b0, sb_r} + {1'b0, nb_r};
    eoff_w     = 64'(start_r) << shift_r;
    elen_w     = 64'(pos - start_r) << shift_r;
    elen_end_w = 64'(count - start_r) << shift_r;
  end

  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    phase_nxt     = phase_r;
    word_nxt      = word_r;
    from_nxt      = from_r;
    start_nxt     = start_r;
    cursor_nxt    = cursor_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sb_nxt        = sb_r;
    nb_nxt        = nb_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_off_nxt   = out_off_r;
    out_len_nxt   = out_len_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = word_r;
    mem_wdata     = fword;
    mem_raddr     = (state_r == S_SRD) ? from_r[BIT_W +: WORD_AW] : word_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_found_nxt = 1'b0;
          out_off_nxt   = '0;
          out_len_nxt   = '0;
          out_stat_nxt  = bbf_pkg::ST_OK;
          unique case (in_func)
            bbf_pkg::FUNC_TOGGLE: begin
              sb_nxt = {1'b0, in_byte_offset} >> shift_r;
              nb_nxt = in_byte_length >> shift_r;
              priority if ((({1'b0, in_byte_offset} | in_byte_length) & low_mask) != '0) begin
                out_stat_nxt  = bbf_pkg::ST_MISALIGN;
                out_valid_nxt = 1'b1;
              end else if (in_byte_length == '0) begin
                out_stat_nxt  = bbf_pkg::ST_ZERO_LEN;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_CHK;
              end
            end
            bbf_pkg::FUNC_FORMAT: begin
              fmt_nxt   = 1'b1;
              word_nxt  = '0;
              state_nxt = S_CLR;
            end
            bbf_pkg::FUNC_RESTART: begin
              cursor_nxt    = '0;
              out_valid_nxt = 1'b1;
            end
            bbf_pkg::FUNC_NEXT: begin
              if (cursor_r >= count) begin
                out_valid_nxt = 1'b1;
              end else begin
                phase_nxt = 1'b0;
                from_nxt  = cursor_r;
                state_nxt = S_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        mem_we = 1'b1;
        if (word_r == WORD_AW'(NUM_WORDS - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = fmt_r;
        end else begin
          word_nxt = word_r + WORD_AW'(1);
        end
      end
      S_CHK: begin
        if (range_sum > (bbf_pkg::LEN_W+1)'(count)) begin
          out_stat_nxt  = bbf_pkg::ST_RANGE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          a_nxt     = sb_r[BLK_W-1:0];
          b_nxt     = range_sum[BLK_W-1:0];
          word_nxt  = sb_r[BIT_W +: WORD_AW];
          state_nxt = S_TRD;
        end
      end
      S_TRD: state_nxt = S_TWR;
      S_TWR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r ^ tmask;
        if (nxt_base >= b_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          word_nxt  = word_r + WORD_AW'(1);
          state_nxt = S_TRD;
        end
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        if (!scan_hit && snext < count) begin
          from_nxt  = snext;
          state_nxt = S_SRD;
        end else if (!phase_r) begin
          if (!scan_hit) begin
            cursor_nxt    = count;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            start_nxt = pos;
            from_nxt  = pos;
            phase_nxt = 1'b1;
            state_nxt = S_SRD;
          end
        end else begin
          if (!scan_hit) begin
            cursor_nxt  = count;
            out_len_nxt = elen_end_w[bbf_pkg::LEN_W-1:0];
          end else begin
            cursor_nxt  = pos;
            out_len_nxt = elen_w[bbf_pkg::LEN_W-1:0];
          end
          out_found_nxt = 1'b1;
          out_off_nxt   = eoff_w[bbf_pkg::OFF_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fmt_r       <= 1'b0;
      word_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      word_r      <= word_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    from_r      <= from_nxt;
    start_r     <= start_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    sb_r        <= sb_nxt;
    nb_r        <= nb_nxt;
    out_found_r <= out_found_nxt;
    out_off_r   <= out_off_nxt;
    out_len_r   <= out_len_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_ext_offset = out_off_r;
  assign out_ext_length = out_len_r;
  assign out_status     = out_stat_r;

  `BBF_ASSERT_IMP(a_word_when_idle, out_valid, !busy, "result word while busy")
  `BBF_ASSERT_IMP(a_found_ok, out_valid && out_found, out_status == bbf_pkg::ST_OK, "found not ok")
  `BBF_ASSERT_NXT(a_start_progress, start && !busy, busy || out_valid, "accepted word dropped")
  `BBF_ASSERT_IMP(a_cursor_bound, !busy, cursor_r <= count || cursor_r == $past(cursor_r), "bad cursor")

endmodule

`default_nettype wire
